>>> hw/rtl/programmable_sound_generator_defines.svh
// ----------------------------------------------------------------------------
// Sound generator assertion macros
// Shared concurrent assertion forms for the sound generator checkers.
// ----------------------------------------------------------------------------
`ifndef PROGRAMMABLE_SOUND_GENERATOR_DEFINES_SVH
`define PROGRAMMABLE_SOUND_GENERATOR_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define PSG_ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define PSG_ASSERT(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/psg_pkg.sv
// ----------------------------------------------------------------------------
// Sound generator package
// Widths, codes, register map and amplitude tables of the sound generator.
// ----------------------------------------------------------------------------
`default_nettype none

package psg_pkg;

   // Field and state widths
   localparam int unsigned FRACTION_BITS_DEFAULT = 24;
   localparam int unsigned STEP_INC_W   = 29;
   localparam int unsigned MODE_W       = 2;
   localparam int unsigned ADDR_W       = 4;
   localparam int unsigned DATA_W       = 8;
   localparam int unsigned LEVEL_W      = 16;
   localparam int unsigned NUM_CH       = 3;
   localparam int unsigned NUM_REGS     = 16;
   localparam int unsigned TONE_W       = 12;
   localparam int unsigned NOISE_PER_W  = 6;
   localparam int unsigned NOISE_LFSR_W = 17;
   localparam int unsigned ENV_PER_W    = 16;
   localparam int unsigned ENV_POS_W    = 5;
   localparam int unsigned VOL_W        = 5;
   localparam int unsigned CSR_INDEX_W  = 1;

   // Item modes
   localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_TICK  = 2'd2;

   // Configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_CHIP_MODEL     = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_INCREMENT = 1'b1;

   // Sound register map
   localparam logic [ADDR_W-1:0] REG_TONE_A_FINE   = 4'd0;
   localparam logic [ADDR_W-1:0] REG_TONE_A_COARSE = 4'd1;
   localparam logic [ADDR_W-1:0] REG_TONE_B_FINE   = 4'd2;
   localparam logic [ADDR_W-1:0] REG_TONE_B_COARSE = 4'd3;
   localparam logic [ADDR_W-1:0] REG_TONE_C_FINE   = 4'd4;
   localparam logic [ADDR_W-1:0] REG_TONE_C_COARSE = 4'd5;
   localparam logic [ADDR_W-1:0] REG_NOISE_PERIOD  = 4'd6;
   localparam logic [ADDR_W-1:0] REG_MIXER         = 4'd7;
   localparam logic [ADDR_W-1:0] REG_VOLUME_A      = 4'd8;
   localparam logic [ADDR_W-1:0] REG_VOLUME_B      = 4'd9;
   localparam logic [ADDR_W-1:0] REG_VOLUME_C      = 4'd10;
   localparam logic [ADDR_W-1:0] REG_ENV_FINE      = 4'd11;
   localparam logic [ADDR_W-1:0] REG_ENV_COARSE    = 4'd12;
   localparam logic [ADDR_W-1:0] REG_ENV_SHAPE     = 4'd13;

   // Envelope direction codes
   localparam logic [1:0] ENV_STOP = 2'd0;
   localparam logic [1:0] ENV_UP   = 2'd1;
   localparam logic [1:0] ENV_DOWN = 2'd2;

   localparam logic [ENV_POS_W-1:0]    ENV_POS_TOP = 5'h1F;
   localparam logic [NOISE_LFSR_W-1:0] NOISE_SEED  = 17'd1111;

   // Shape codes that stand for the two classic one-shot shapes
   localparam logic [3:0] SHAPE_DECAY_HOLD  = 4'd9;
   localparam logic [3:0] SHAPE_ATTACK_HOLD = 4'd15;

   // Amplitude tables: coarse (sixteen doubled steps) and fine
   localparam logic [LEVEL_W-1:0] AMP_TABLE [2][32] = '{
      '{16'h0000, 16'h0000, 16'h0340, 16'h0340, 16'h04C0, 16'h04C0, 16'h06F2, 16'h06F2,
        16'h0A44, 16'h0A44, 16'h0F13, 16'h0F13, 16'h1510, 16'h1510, 16'h227E, 16'h227E,
        16'h289F, 16'h289F, 16'h414E, 16'h414E, 16'h5B21, 16'h5B21, 16'h7258, 16'h7258,
        16'h905E, 16'h905E, 16'hB550, 16'hB550, 16'hD7A0, 16'hD7A0, 16'hFFFF, 16'hFFFF},
      '{16'h0000, 16'h0000, 16'h00EF, 16'h01D0, 16'h0290, 16'h032A, 16'h03EE, 16'h04D2,
        16'h0611, 16'h0782, 16'h0912, 16'h0A36, 16'h0C31, 16'h0EB6, 16'h1130, 16'h13A0,
        16'h1751, 16'h1BF5, 16'h20E2, 16'h2594, 16'h2CA1, 16'h357F, 16'h3E45, 16'h475E,
        16'h5502, 16'h6620, 16'h7730, 16'h8844, 16'hA1D2, 16'hC102, 16'hE0A2, 16'hFFFF}
   };

   // Look up one amplitude
   function automatic logic [LEVEL_W-1:0] amp_level(input logic model,
                                                    input logic [VOL_W-1:0] idx);
      return AMP_TABLE[model][idx];
   endfunction

   // Keep only the implemented bits of a register write
   function automatic logic [DATA_W-1:0] mask_write(input logic [ADDR_W-1:0] addr,
                                                    input logic [DATA_W-1:0] data);
      logic [DATA_W-1:0] res;
      case (addr) inside
         REG_TONE_A_COARSE, REG_TONE_B_COARSE, REG_TONE_C_COARSE, REG_ENV_SHAPE:
            res = {4'h0, data[3:0]};
         REG_NOISE_PERIOD, REG_VOLUME_A, REG_VOLUME_B, REG_VOLUME_C:
            res = {3'h0, data[4:0]};
         default:
            res = data;
      endcase
      return res;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/psg_if.sv
// ----------------------------------------------------------------------------
// Sound generator channels
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

// Request word: register write, register read or tick
interface psg_req_if;
   logic                          valid;
   logic                          ready;
   logic [psg_pkg::MODE_W-1:0]    mode;
   logic [psg_pkg::ADDR_W-1:0]    reg_addr;
   logic [psg_pkg::DATA_W-1:0]    reg_data;

   modport source (output valid, output mode, output reg_addr, output reg_data,
                   input ready);
   modport sink   (input valid, input mode, input reg_addr, input reg_data,
                   output ready);
endinterface

// Response word: read data and three channel levels
interface psg_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [psg_pkg::DATA_W-1:0]    read_data;
   logic [psg_pkg::LEVEL_W-1:0]   level_a;
   logic [psg_pkg::LEVEL_W-1:0]   level_b;
   logic [psg_pkg::LEVEL_W-1:0]   level_c;

   modport source (output valid, output read_data, output level_a, output level_b,
                   output level_c, input ready);
   modport sink   (input valid, input read_data, input level_a, input level_b,
                   input level_c, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/programmable_sound_generator.sv
// ----------------------------------------------------------------------------
// Programmable sound generator
// Three-channel square-wave generator with noise and envelope.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one word per item: a register write, a register read or
//   a tick. rsp_chan returns exactly one word per request word: read data for
//   a read, three channel levels for a tick, all zero otherwise.
//   csr_write_en/csr_index/csr_write_data set the amplitude table select and
//   the step increment; write them only while no word is in flight.
//   A word accepted on req_chan is loaded into the request register; it
//   moves on through the update logic into the response register when that
//   register is free or drains. Throughput is one word per cycle while the
//   receiver keeps rsp_chan.ready high; the path from the request register
//   through the counter adders and the table lookup limits the clock period.
//   Reset (synchronous, active high) clears the register file, tone, noise
//   and envelope state, selects the coarse table, sets the step increment to
//   one whole step and empties the pipeline. When the receiver stalls, the
//   response register holds its word and the request register keeps one
//   more; req_chan.ready drops only when both are full.
// ----------------------------------------------------------------------------
`default_nettype none

module programmable_sound_generator #(
   parameter int unsigned FRACTION_BITS = psg_pkg::FRACTION_BITS_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_write_en,
   input  wire logic [psg_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [psg_pkg::STEP_INC_W-1:0]      csr_write_data,
   psg_req_if.sink                                  req_chan,
   psg_rsp_if.source                                rsp_chan
);

   localparam int unsigned NCH     = psg_pkg::NUM_CH;
   localparam int unsigned ACC_W   = ((FRACTION_BITS > psg_pkg::STEP_INC_W) ?
                                      FRACTION_BITS : psg_pkg::STEP_INC_W) + 1;
   localparam int unsigned STEPS_W = ACC_W - FRACTION_BITS;
   localparam int unsigned SUM_W   = ((psg_pkg::ENV_PER_W > STEPS_W) ?
                                      psg_pkg::ENV_PER_W : STEPS_W) + 1;
   localparam logic [psg_pkg::STEP_INC_W-1:0] STEP_ONE =
      {{(psg_pkg::STEP_INC_W-1){1'b0}}, 1'b1} << FRACTION_BITS;

   // Configuration
   logic                                chip_model_ff;
   logic [psg_pkg::STEP_INC_W-1:0]      step_inc_ff;

   // Request and response registers
   logic                                in_vld_ff, in_vld_in;
   logic [psg_pkg::MODE_W-1:0]          in_mode_ff;
   logic [psg_pkg::ADDR_W-1:0]          in_addr_ff;
   logic [psg_pkg::DATA_W-1:0]          in_data_ff;
   logic                                out_vld_ff, out_vld_in;
   logic [psg_pkg::DATA_W-1:0]          out_rdata_ff, out_rdata_in;
   logic [psg_pkg::LEVEL_W-1:0]         out_level_ff [NCH];
   logic [psg_pkg::LEVEL_W-1:0]         out_level_in [NCH];

   // Sound state
   logic [psg_pkg::DATA_W-1:0]          reg_file_ff      [psg_pkg::NUM_REGS];
   logic [psg_pkg::DATA_W-1:0]          reg_file_in      [psg_pkg::NUM_REGS];
   logic [psg_pkg::TONE_W-1:0]          tone_period_ff   [NCH];
   logic [psg_pkg::TONE_W-1:0]          tone_period_in   [NCH];
   logic [psg_pkg::TONE_W-1:0]          tone_cnt_ff      [NCH];
   logic [psg_pkg::TONE_W-1:0]          tone_cnt_in      [NCH];
   logic [NCH-1:0]                      tone_out_ff, tone_out_in;
   logic [NCH-1:0]                      tone_en_ff, tone_en_in;
   logic [NCH-1:0]                      noise_en_ff, noise_en_in;
   logic [NCH-1:0]                      use_env_ff, use_env_in;
   logic [psg_pkg::VOL_W-1:0]           vol_idx_ff       [NCH];
   logic [psg_pkg::VOL_W-1:0]           vol_idx_in       [NCH];
   logic [psg_pkg::NOISE_LFSR_W-1:0]    noise_shift_ff, noise_shift_in;
   logic [psg_pkg::NOISE_PER_W-1:0]     noise_period_ff, noise_period_in;
   logic [psg_pkg::NOISE_PER_W-1:0]     noise_cnt_ff, noise_cnt_in;
   logic [psg_pkg::ENV_PER_W-1:0]       env_period_ff, env_period_in;
   logic [psg_pkg::ENV_PER_W-1:0]       env_cnt_ff, env_cnt_in;
   logic [psg_pkg::ENV_POS_W-1:0]       env_pos_ff, env_pos_in;
   logic [1:0]                          env_dir_ff, env_dir_in;
   logic                                env_hold_ff, env_hold_in;
   logic                                env_alt_ff, env_alt_in;
   logic                                env_final_ff, env_final_in;
   logic [FRACTION_BITS-1:0]            phase_ff, phase_in;

   // Datapath wires
   logic                                advance;
   logic                                do_write;
   logic                                do_tick;
   logic [psg_pkg::DATA_W-1:0]          wdata;
   logic [ACC_W-1:0]                    acc;
   logic [STEPS_W-1:0]                  steps;
   logic [SUM_W-1:0]                    env_sum;
   logic [SUM_W-1:0]                    noise_sum;
   logic [SUM_W-1:0]                    tone_sum         [NCH];

   // Move the request word on when the response register is free or drains
   assign advance        = in_vld_ff && (!out_vld_ff || rsp_chan.ready);
   assign req_chan.ready = !in_vld_ff || advance;
   assign do_write       = advance && (in_mode_ff == psg_pkg::MODE_WRITE);
   assign do_tick        = advance && (in_mode_ff == psg_pkg::MODE_TICK);
   assign wdata          = psg_pkg::mask_write(in_addr_ff, in_data_ff);

   // Phase accumulator: whole part gives the step count of this tick
   assign acc   = ACC_W'(phase_ff) + ACC_W'(step_inc_ff);
   assign steps = acc[ACC_W-1:FRACTION_BITS];

   assign env_sum   = SUM_W'(env_cnt_ff) + SUM_W'(steps);
   assign noise_sum = SUM_W'(noise_cnt_ff) + SUM_W'(steps);
   always_comb begin
      for (int c = 0; c < NCH; c++) begin
         tone_sum[c] = SUM_W'(tone_cnt_ff[c]) + SUM_W'(steps);
      end
   end

   // Next sound state for a register write or a tick
   always_comb begin
      logic [1:0]                      ch;
      logic [3:0]                      shape;
      logic [psg_pkg::ENV_POS_W:0]     pos6;
      logic [1:0]                      dir;
      logic                            fb;

      reg_file_in     = reg_file_ff;
      tone_period_in  = tone_period_ff;
      tone_cnt_in     = tone_cnt_ff;
      tone_out_in     = tone_out_ff;
      tone_en_in      = tone_en_ff;
      noise_en_in     = noise_en_ff;
      use_env_in      = use_env_ff;
      vol_idx_in      = vol_idx_ff;
      noise_shift_in  = noise_shift_ff;
      noise_period_in = noise_period_ff;
      noise_cnt_in    = noise_cnt_ff;
      env_period_in   = env_period_ff;
      env_cnt_in      = env_cnt_ff;
      env_pos_in      = env_pos_ff;
      env_dir_in      = env_dir_ff;
      env_hold_in     = env_hold_ff;
      env_alt_in      = env_alt_ff;
      env_final_in    = env_final_ff;
      phase_in        = phase_ff;
      ch              = in_addr_ff[2:1];
      shape           = wdata[3:0];
      pos6            = {1'b0, env_pos_ff};
      dir             = env_dir_ff;
      fb              = noise_shift_ff[0] ^ noise_shift_ff[2];

      if (do_write) begin
         reg_file_in[in_addr_ff] = wdata;
         unique case (in_addr_ff) inside
            psg_pkg::REG_TONE_A_FINE, psg_pkg::REG_TONE_A_COARSE,
            psg_pkg::REG_TONE_B_FINE, psg_pkg::REG_TONE_B_COARSE,
            psg_pkg::REG_TONE_C_FINE, psg_pkg::REG_TONE_C_COARSE: begin
               tone_period_in[ch] = {reg_file_in[{1'b0, ch, 1'b1}][3:0],
                                     reg_file_in[{1'b0, ch, 1'b0}]};
               if (tone_period_in[ch] == '0) begin
                  tone_out_in[ch] = 1'b0;
               end
            end
            psg_pkg::REG_NOISE_PERIOD: begin
               noise_period_in = {wdata[4:0], 1'b0};
            end
            psg_pkg::REG_MIXER: begin
               tone_en_in  = ~wdata[2:0];
               noise_en_in = ~wdata[5:3];
            end
            psg_pkg::REG_VOLUME_A, psg_pkg::REG_VOLUME_B,
            psg_pkg::REG_VOLUME_C: begin
               use_env_in[in_addr_ff[1:0]] = wdata[4];
               vol_idx_in[in_addr_ff[1:0]] = {wdata[3:0], 1'b1};
            end
            psg_pkg::REG_ENV_FINE, psg_pkg::REG_ENV_COARSE: begin
               env_period_in = {reg_file_in[psg_pkg::REG_ENV_COARSE],
                                reg_file_in[psg_pkg::REG_ENV_FINE]};
            end
            psg_pkg::REG_ENV_SHAPE: begin
               // Shapes without the continue bit act as the one-shot shapes
               if (!shape[3]) begin
                  shape = shape[2] ? psg_pkg::SHAPE_ATTACK_HOLD : psg_pkg::SHAPE_DECAY_HOLD;
               end
               env_cnt_in   = '0;
               env_hold_in  = shape[0];
               env_final_in = shape[2] ^ shape[1];
               env_alt_in   = shape[1] && !shape[0];
               env_pos_in   = shape[2] ? '0 : psg_pkg::ENV_POS_TOP;
               env_dir_in   = shape[2] ? psg_pkg::ENV_UP : psg_pkg::ENV_DOWN;
            end
            default: begin
            end
         endcase
      end else if (do_tick) begin
         phase_in = acc[FRACTION_BITS-1:0];

         // Envelope: step position on period hit, then bounce, wrap or hold
         if (env_sum >= SUM_W'(env_period_ff)) begin
            env_cnt_in = '0;
            if (dir == psg_pkg::ENV_UP) begin
               pos6 = pos6 + 1'b1;
            end else if (dir == psg_pkg::ENV_DOWN) begin
               pos6 = pos6 - 1'b1;
            end
            if (pos6[psg_pkg::ENV_POS_W]) begin
               if (env_alt_ff) begin
                  if (dir == psg_pkg::ENV_UP) begin
                     dir  = psg_pkg::ENV_DOWN;
                     pos6 = pos6 - 1'b1;
                  end else if (dir == psg_pkg::ENV_DOWN) begin
                     dir  = psg_pkg::ENV_UP;
                     pos6 = pos6 + 1'b1;
                  end
               end else begin
                  pos6[psg_pkg::ENV_POS_W] = 1'b0;
               end
               if (env_hold_ff) begin
                  dir  = psg_pkg::ENV_STOP;
                  pos6 = env_final_ff ? {1'b0, psg_pkg::ENV_POS_TOP} : '0;
               end
            end
            env_pos_in = pos6[psg_pkg::ENV_POS_W-1:0];
            env_dir_in = dir;
         end else begin
            env_cnt_in = env_sum[psg_pkg::ENV_PER_W-1:0];
         end

         // Noise: shift the LFSR on period hit
         if (noise_sum >= SUM_W'(noise_period_ff)) begin
            noise_cnt_in   = '0;
            noise_shift_in = {fb, noise_shift_ff[psg_pkg::NOISE_LFSR_W-1:1]};
         end else begin
            noise_cnt_in = noise_sum[psg_pkg::NOISE_PER_W-1:0];
         end

         // Tones: toggle on period hit, hold low for a zero period
         for (int c = 0; c < NCH; c++) begin
            if (tone_sum[c] >= SUM_W'(tone_period_ff[c])) begin
               tone_cnt_in[c] = '0;
               if (tone_period_ff[c] != '0) begin
                  tone_out_in[c] = !tone_out_ff[c];
               end
            end else begin
               tone_cnt_in[c] = tone_sum[c][psg_pkg::TONE_W-1:0];
            end
         end
      end
   end

   // Response word: read data or gated channel levels
   always_comb begin
      logic gate;
      out_rdata_in = '0;
      if (in_mode_ff == psg_pkg::MODE_READ) begin
         out_rdata_in = reg_file_ff[in_addr_ff];
      end
      for (int c = 0; c < NCH; c++) begin
         gate = (tone_out_in[c] && tone_en_ff[c]) ||
                (noise_shift_in[1] && noise_en_ff[c]);
         out_level_in[c] = '0;
         if ((in_mode_ff == psg_pkg::MODE_TICK) && !gate) begin
            out_level_in[c] = psg_pkg::amp_level(chip_model_ff,
                                                use_env_ff[c] ? env_pos_in : vol_idx_ff[c]);
         end
      end
   end

   // Handshake state of both registers
   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_chan.valid && req_chan.ready) begin
         in_vld_in = 1'b1;
      end else if (advance) begin
         in_vld_in = 1'b0;
      end
      out_vld_in = out_vld_ff;
      if (advance) begin
         out_vld_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_vld_in = 1'b0;
      end
   end

   // Control and sound state
   always_ff @(posedge clock) begin
      if (reset) begin
         chip_model_ff   <= 1'b0;
         step_inc_ff     <= STEP_ONE;
         in_vld_ff       <= 1'b0;
         out_vld_ff      <= 1'b0;
         for (int r = 0; r < psg_pkg::NUM_REGS; r++) begin
            reg_file_ff[r] <= '0;
         end
         for (int c = 0; c < NCH; c++) begin
            tone_period_ff[c] <= psg_pkg::TONE_W'(1);
            tone_cnt_ff[c]    <= '0;
            vol_idx_ff[c]     <= '0;
         end
         tone_out_ff     <= '0;
         tone_en_ff      <= '0;
         noise_en_ff     <= '0;
         use_env_ff      <= '0;
         noise_shift_ff  <= psg_pkg::NOISE_SEED;
         noise_period_ff <= '0;
         noise_cnt_ff    <= '0;
         env_period_ff   <= psg_pkg::ENV_PER_W'(1);
         env_cnt_ff      <= '0;
         env_pos_ff      <= '0;
         env_dir_ff      <= psg_pkg::ENV_STOP;
         env_hold_ff     <= 1'b0;
         env_alt_ff      <= 1'b0;
         env_final_ff    <= 1'b0;
         phase_ff        <= '0;
      end else begin
         if (csr_write_en) begin
            if (csr_index == psg_pkg::CSR_CHIP_MODEL) begin
               chip_model_ff <= csr_write_data[0];
            end
            if (csr_index == psg_pkg::CSR_STEP_INCREMENT) begin
               step_inc_ff <= csr_write_data;
            end
         end
         in_vld_ff       <= in_vld_in;
         out_vld_ff      <= out_vld_in;
         reg_file_ff     <= reg_file_in;
         tone_period_ff  <= tone_period_in;
         tone_cnt_ff     <= tone_cnt_in;
         vol_idx_ff      <= vol_idx_in;
         tone_out_ff     <= tone_out_in;
         tone_en_ff      <= tone_en_in;
         noise_en_ff     <= noise_en_in;
         use_env_ff      <= use_env_in;
         noise_shift_ff  <= noise_shift_in;
         noise_period_ff <= noise_period_in;
         noise_cnt_ff    <= noise_cnt_in;
         env_period_ff   <= env_period_in;
         env_cnt_ff      <= env_cnt_in;
         env_pos_ff      <= env_pos_in;
         env_dir_ff      <= env_dir_in;
         env_hold_ff     <= env_hold_in;
         env_alt_ff      <= env_alt_in;
         env_final_ff    <= env_final_in;
         phase_ff        <= phase_in;
      end
   end

   // Payload registers: capture the request word, load the response word
   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_mode_ff <= req_chan.mode;
         in_addr_ff <= req_chan.reg_addr;
         in_data_ff <= req_chan.reg_data;
      end
      if (advance) begin
         out_rdata_ff <= out_rdata_in;
         out_level_ff <= out_level_in;
      end
   end

   assign rsp_chan.valid     = out_vld_ff;
   assign rsp_chan.read_data = out_rdata_ff;
   assign rsp_chan.level_a   = out_level_ff[0];
   assign rsp_chan.level_b   = out_level_ff[1];
   assign rsp_chan.level_c   = out_level_ff[2];

endmodule

`default_nettype wire

>>> hw/rtl/psg_checker.sv
// ----------------------------------------------------------------------------
// Sound generator port checker
// Concurrent checks on the sound generator's channel ports.
// ----------------------------------------------------------------------------
`default_nettype none

`include "programmable_sound_generator_defines.svh"

module psg_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_ready,
   input wire logic                            rsp_valid,
   input wire logic                            rsp_ready,
   input wire logic [psg_pkg::DATA_W-1:0]      rsp_read_data,
   input wire logic [psg_pkg::LEVEL_W-1:0]     rsp_level_a,
   input wire logic [psg_pkg::LEVEL_W-1:0]     rsp_level_b,
   input wire logic [psg_pkg::LEVEL_W-1:0]     rsp_level_c
);

   logic                                            rsp_stall;
   logic [psg_pkg::DATA_W+3*psg_pkg::LEVEL_W-1:0]   rsp_word;
   logic                                            rsp_read_word;
   logic                                            rsp_quiet;

   // Gather the response word and its conditions
   assign rsp_stall     = rsp_valid && !rsp_ready;
   assign rsp_word      = {rsp_read_data, rsp_level_a, rsp_level_b, rsp_level_c};
   assign rsp_read_word = rsp_valid && (rsp_read_data != '0);
   assign rsp_quiet     = ({rsp_level_a, rsp_level_b, rsp_level_c} == '0);

   // A stalled response word stays offered
   `PSG_ASSERT_RST(a_rsp_hold, clock, reset, rsp_stall |=> rsp_valid, "stalled word dropped")

   // A stalled response word does not change
   `PSG_ASSERT_RST(a_rsp_stable, clock, reset, rsp_stall |=> $stable(rsp_word), "stalled word changed")

   // Reset empties the pipeline and opens the request side
   `PSG_ASSERT(a_reset_empty, clock, reset |=> !rsp_valid && req_ready, "not empty after reset")

   // Read data and channel levels never come from the same word
   `PSG_ASSERT_RST(a_read_no_level, clock, reset, rsp_read_word |-> rsp_quiet, "read word has levels")

endmodule

bind programmable_sound_generator psg_checker u_psg_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_read_data (rsp_chan.read_data),
   .rsp_level_a   (rsp_chan.level_a),
   .rsp_level_b   (rsp_chan.level_b),
   .rsp_level_c   (rsp_chan.level_c)
);

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sound generator testbench
// Drives register writes, register reads and ticks through the request
// channel under random bursts and receiver stalls. A shadow model of the
// register file, tone, noise and envelope state predicts every response
// word, which is compared field by field in arrival order. A short table of
// directed words runs first, then random phases under several table and
// step settings.
// ----------------------------------------------------------------------------

module tb_top;
   import psg_pkg::*;

   localparam int unsigned FRAC       = FRACTION_BITS_DEFAULT;
   localparam int unsigned LIMIT      = 400000;
   localparam int unsigned LONG_HOLD  = 400;
   localparam int unsigned NUM_PHASES = 8;
   localparam int unsigned PHASE_WORDS = 205;

   localparam logic [MODE_W-1:0] MODE_NONE   = 2'd3;
   localparam logic [ADDR_W-1:0] REG_SPARE_A = 4'd14;
   localparam logic [ADDR_W-1:0] REG_SPARE_B = 4'd15;

   typedef struct packed {
      logic [DATA_W-1:0]  read_data;
      logic [LEVEL_W-1:0] level_a;
      logic [LEVEL_W-1:0] level_b;
      logic [LEVEL_W-1:0] level_c;
   } psg_result_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] data;
      logic              typed;
      psg_result_type    want;
   } psg_word_type;

   typedef enum {RX_OPEN, RX_RANDOM, RX_PATTERN} rx_style_type;

   localparam psg_result_type QUIET = '0;

   logic clock;
   logic reset;
   logic                   csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [STEP_INC_W-1:0]  csr_write_data;

   psg_req_if req ();
   psg_rsp_if rsp ();

   programmable_sound_generator dut (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .req_chan       (req),
      .rsp_chan       (rsp)
   );

   // Shadow configuration
   logic                  cfg_chip_model;
   logic [STEP_INC_W-1:0] cfg_step;

   // Shadow sound state
   logic [DATA_W-1:0]       sh_regs [NUM_REGS];
   logic [TONE_W-1:0]       sh_tone_period [NUM_CH];
   logic [16:0]             sh_tone_cnt [NUM_CH];
   logic                    sh_tone_out [NUM_CH];
   logic                    sh_tone_en [NUM_CH];
   logic                    sh_noise_en [NUM_CH];
   logic                    sh_use_env [NUM_CH];
   logic [VOL_W-1:0]        sh_vol_idx [NUM_CH];
   logic [NOISE_LFSR_W-1:0] sh_lfsr;
   logic [NOISE_PER_W-1:0]  sh_noise_period;
   logic [16:0]             sh_noise_cnt;
   logic [ENV_PER_W-1:0]    sh_env_period;
   logic [16:0]             sh_env_cnt;
   logic [5:0]              sh_env_pos;
   logic [1:0]              sh_env_dir;
   logic                    sh_env_hold;
   logic                    sh_env_alt;
   logic                    sh_env_final_high;
   logic [FRAC-1:0]         sh_phase;

   psg_result_type rsp_due [$];
   psg_word_type   sent_words [$];
   int unsigned errors = 0;
   int unsigned words_sent = 0;
   int unsigned burst_left = 0;
   int unsigned cycles = 0;
   bit          hold_rsp_request = 1'b0;

   // Directed words: expectations typed in where they are obvious
   psg_word_type directed_rows [26] = '{
      '{MODE_READ,  REG_TONE_A_FINE,   8'h00, 1'b1, QUIET},
      '{MODE_TICK,  REG_TONE_A_FINE,   8'h00, 1'b1, QUIET},
      '{MODE_NONE,  REG_SPARE_B,       8'hFF, 1'b1, QUIET},
      '{MODE_WRITE, REG_TONE_A_FINE,   8'hFF, 1'b1, QUIET},
      '{MODE_READ,  REG_TONE_A_FINE,   8'h00, 1'b1, '{8'hFF, 16'h0000, 16'h0000, 16'h0000}},
      '{MODE_WRITE, REG_TONE_A_COARSE, 8'hFF, 1'b1, QUIET},
      '{MODE_READ,  REG_TONE_A_COARSE, 8'h00, 1'b1, '{8'h0F, 16'h0000, 16'h0000, 16'h0000}},
      '{MODE_WRITE, REG_NOISE_PERIOD,  8'hFF, 1'b1, QUIET},
      '{MODE_READ,  REG_NOISE_PERIOD,  8'h00, 1'b1, '{8'h1F, 16'h0000, 16'h0000, 16'h0000}},
      '{MODE_WRITE, REG_VOLUME_A,      8'h0F, 1'b1, QUIET},
      '{MODE_WRITE, REG_MIXER,         8'hFF, 1'b1, QUIET},
      '{MODE_TICK,  REG_TONE_A_FINE,   8'h00, 1'b1, '{8'h00, 16'hFFFF, 16'h0000, 16'h0000}},
      '{MODE_WRITE, REG_SPARE_B,       8'hFF, 1'b1, QUIET},
      '{MODE_READ,  REG_SPARE_B,       8'h00, 1'b1, '{8'hFF, 16'h0000, 16'h0000, 16'h0000}},
      '{MODE_WRITE, REG_VOLUME_B,      8'h1F, 1'b0, QUIET},
      '{MODE_WRITE, REG_ENV_SHAPE,     8'h00, 1'b0, QUIET},
      '{MODE_TICK,  REG_TONE_A_FINE,   8'h00, 1'b0, QUIET},
      '{MODE_WRITE, REG_ENV_FINE,      8'h00, 1'b0, QUIET},
      '{MODE_WRITE, REG_ENV_COARSE,    8'h00, 1'b0, QUIET},
      '{MODE_WRITE, REG_ENV_SHAPE,     8'h04, 1'b0, QUIET},
      '{MODE_TICK,  REG_TONE_A_FINE,   8'h00, 1'b0, QUIET},
      '{MODE_WRITE, REG_ENV_SHAPE,     8'h0E, 1'b0, QUIET},
      '{MODE_TICK,  REG_TONE_A_FINE,   8'h00, 1'b0, QUIET},
      '{MODE_WRITE, REG_MIXER,         8'h00, 1'b0, QUIET},
      '{MODE_WRITE, REG_TONE_B_FINE,   8'h00, 1'b0, QUIET},
      '{MODE_TICK,  REG_TONE_A_FINE,   8'h00, 1'b0, QUIET}
   };

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Advance the shadow state by one word and return the response it causes
   function automatic psg_result_type predict_word(input logic [MODE_W-1:0] mode,
                                                   input logic [ADDR_W-1:0] addr,
                                                   input logic [DATA_W-1:0] data);
      psg_result_type res;
      logic [DATA_W-1:0] v;
      logic [3:0] shape;
      logic attack, alt, noise_bit, gate;
      logic [31:0] acc, sum;
      int unsigned steps;
      int c;
      res = '0;
      if (mode == MODE_WRITE) begin
         // Drop unimplemented bits, then decode
         v = data;
         case (addr)
            REG_TONE_A_COARSE, REG_TONE_B_COARSE, REG_TONE_C_COARSE, REG_ENV_SHAPE:
               v = {4'h0, data[3:0]};
            REG_NOISE_PERIOD, REG_VOLUME_A, REG_VOLUME_B, REG_VOLUME_C:
               v = {3'h0, data[4:0]};
            default: ;
         endcase
         sh_regs[addr] = v;
         case (addr)
            REG_TONE_A_FINE, REG_TONE_A_COARSE, REG_TONE_B_FINE,
            REG_TONE_B_COARSE, REG_TONE_C_FINE, REG_TONE_C_COARSE: begin
               c = addr[3:1];
               sh_tone_period[c] = {sh_regs[2*c+1][3:0], sh_regs[2*c]};
               if (sh_tone_period[c] == '0) sh_tone_out[c] = 1'b0;
            end
            REG_NOISE_PERIOD: sh_noise_period = {v[4:0], 1'b0};
            REG_MIXER: begin
               for (c = 0; c < NUM_CH; c++) begin
                  sh_tone_en[c]  = !v[c];
                  sh_noise_en[c] = !v[c+3];
               end
            end
            REG_VOLUME_A, REG_VOLUME_B, REG_VOLUME_C: begin
               c = addr - REG_VOLUME_A;
               sh_use_env[c] = v[4];
               sh_vol_idx[c] = {v[3:0], 1'b1};
            end
            REG_ENV_FINE, REG_ENV_COARSE:
               sh_env_period = {sh_regs[REG_ENV_COARSE], sh_regs[REG_ENV_FINE]};
            REG_ENV_SHAPE: begin
               // Codes below 8 fold onto the two one-shot shapes
               shape = v[3:0];
               if (shape < 4) shape = SHAPE_DECAY_HOLD;
               else if (shape < 8) shape = SHAPE_ATTACK_HOLD;
               sh_env_cnt = '0;
               sh_env_hold = shape[0];
               alt = shape[1];
               attack = shape[2];
               sh_env_final_high = attack != alt;
               sh_env_alt = alt && !sh_env_hold;
               if (attack) begin
                  sh_env_pos = '0;
                  sh_env_dir = ENV_UP;
               end else begin
                  sh_env_pos = {1'b0, ENV_POS_TOP};
                  sh_env_dir = ENV_DOWN;
               end
            end
            default: ;
         endcase
      end else if (mode == MODE_READ) begin
         res.read_data = sh_regs[addr];
      end else if (mode == MODE_TICK) begin
         // Whole steps out of the phase accumulator
         acc = 32'(sh_phase) + 32'(cfg_step);
         steps = acc >> FRAC;
         sh_phase = acc[FRAC-1:0];

         // Envelope
         sum = 32'(sh_env_cnt) + steps;
         if (sum < 32'(sh_env_period)) begin
            sh_env_cnt = sum[16:0];
         end else begin
            sh_env_cnt = '0;
            if (sh_env_dir == ENV_UP) sh_env_pos = sh_env_pos + 6'd1;
            else if (sh_env_dir == ENV_DOWN) sh_env_pos = sh_env_pos - 6'd1;
            if (sh_env_pos[5]) begin
               if (sh_env_alt) begin
                  if (sh_env_dir == ENV_UP) begin
                     sh_env_dir = ENV_DOWN;
                     sh_env_pos = sh_env_pos - 6'd1;
                  end else if (sh_env_dir == ENV_DOWN) begin
                     sh_env_dir = ENV_UP;
                     sh_env_pos = sh_env_pos + 6'd1;
                  end
               end else begin
                  sh_env_pos[5] = 1'b0;
               end
               if (sh_env_hold) begin
                  sh_env_dir = ENV_STOP;
                  sh_env_pos = sh_env_final_high ? {1'b0, ENV_POS_TOP} : 6'd0;
               end
            end
         end

         // Noise shift register
         sum = 32'(sh_noise_cnt) + steps;
         if (sum >= 32'(sh_noise_period)) begin
            sh_noise_cnt = '0;
            sh_lfsr = {sh_lfsr[0] ^ sh_lfsr[2], sh_lfsr[NOISE_LFSR_W-1:1]};
         end else begin
            sh_noise_cnt = sum[16:0];
         end
         noise_bit = sh_lfsr[1];

         // Tone counters and channel levels
         for (c = 0; c < NUM_CH; c++) begin
            sum = 32'(sh_tone_cnt[c]) + steps;
            if (sum >= 32'(sh_tone_period[c])) begin
               sh_tone_cnt[c] = '0;
               if (sh_tone_period[c] != '0) sh_tone_out[c] = !sh_tone_out[c];
            end else begin
               sh_tone_cnt[c] = sum[16:0];
            end
            gate = (sh_tone_out[c] && sh_tone_en[c]) || (noise_bit && sh_noise_en[c]);
            if (!gate) begin
               v = {3'h0, sh_use_env[c] ? sh_env_pos[4:0] : sh_vol_idx[c]};
               case (c)
                  0: res.level_a = AMP_TABLE[cfg_chip_model][v[4:0]];
                  1: res.level_b = AMP_TABLE[cfg_chip_model][v[4:0]];
                  default: res.level_c = AMP_TABLE[cfg_chip_model][v[4:0]];
               endcase
            end
         end
      end
      return res;
   endfunction

   task automatic check_field(input string name, input logic [LEVEL_W-1:0] want,
                              input logic [LEVEL_W-1:0] got);
      if (want !== got) begin
         $error("%s: expected %h, got %h", name, want, got);
         errors++;
      end
   endtask

   // Predict on each accepted request word, check each accepted response word
   always @(posedge clock) begin
      psg_result_type want, got;
      psg_word_type w;
      if (!reset) begin
         if (rsp.valid && rsp.ready) begin
            got = '{rsp.read_data, rsp.level_a, rsp.level_b, rsp.level_c};
            if (rsp_due.size() == 0) begin
               $error("response word %h arrived with none due", got);
               errors++;
            end else begin
               want = rsp_due.pop_front();
               check_field("read_data", 16'(want.read_data), 16'(got.read_data));
               check_field("level_a", want.level_a, got.level_a);
               check_field("level_b", want.level_b, got.level_b);
               check_field("level_c", want.level_c, got.level_c);
            end
         end
         if (req.valid && req.ready) begin
            w = '0;
            if (sent_words.size() == 0) begin
               $error("request word accepted that was never offered");
               errors++;
            end else begin
               w = sent_words.pop_front();
            end
            want = predict_word(req.mode, req.reg_addr, req.reg_data);
            if (w.typed) want = w.want;
            rsp_due.push_back(want);
         end
      end
   end

   // Run limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Receiver: stretches of open, random and patterned ready, plus one long hold
   initial begin
      rx_style_type style;
      int unsigned stretch;
      int unsigned tick;
      style = RX_OPEN;
      stretch = 0;
      tick = 0;
      rsp.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_rsp_request) begin
            rsp.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_rsp_request = 1'b0;
         end else begin
            if (stretch == 0) begin
               style = rx_style_type'($urandom_range(0, 2));
               stretch = $urandom_range(16, 96);
            end
            stretch--;
            tick++;
            case (style)
               RX_OPEN:   rsp.ready <= 1'b1;
               RX_RANDOM: rsp.ready <= $urandom_range(0, 1);
               default:   rsp.ready <= (tick % 7) >= 3;
            endcase
            @(posedge clock);
         end
      end
   end

   // Offer one word; gaps fall between bursts of random length
   task automatic send_word(input psg_word_type w);
      if (burst_left == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 12);
      end
      burst_left--;
      sent_words.push_back(w);
      words_sent++;
      req.valid    <= 1'b1;
      req.mode     <= w.mode;
      req.reg_addr <= w.addr;
      req.reg_data <= w.data;
      do @(posedge clock); while (!req.ready);
   endtask

   // Hold the request channel until every due response has come back
   task automatic drain();
      req.valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (sent_words.size() != 0 || rsp_due.size() != 0) @(posedge clock);
   endtask

   task automatic set_config(input logic [CSR_INDEX_W-1:0] index,
                             input logic [STEP_INC_W-1:0] value);
      csr_write_en   <= 1'b1;
      csr_index      <= index;
      csr_write_data <= value;
      if (index == CSR_CHIP_MODEL) cfg_chip_model = value[0];
      else cfg_step = value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   // Register write with data biased toward short periods
   function automatic psg_word_type random_write();
      psg_word_type w;
      w = '0;
      w.mode = MODE_WRITE;
      w.addr = $urandom_range(0, NUM_REGS - 1);
      w.data = $urandom_range(0, 255);
      case (w.addr)
         REG_TONE_A_FINE, REG_TONE_B_FINE, REG_TONE_C_FINE:
            if ($urandom_range(0, 9) < 6) w.data = $urandom_range(0, 12);
         REG_TONE_A_COARSE, REG_TONE_B_COARSE, REG_TONE_C_COARSE:
            if ($urandom_range(0, 9) < 8) w.data = '0;
         REG_ENV_FINE:
            if ($urandom_range(0, 9) < 7) w.data = $urandom_range(0, 6);
         REG_ENV_COARSE:
            if ($urandom_range(0, 19) < 17) w.data = '0;
         default: ;
      endcase
      return w;
   endfunction

   // A few register writes, then a run of ticks with reads and writes mixed in
   task automatic run_scene();
      psg_word_type w;
      repeat ($urandom_range(1, 6)) send_word(random_write());
      repeat ($urandom_range(8, 40)) begin
         w = '0;
         w.addr = $urandom_range(0, NUM_REGS - 1);
         w.data = $urandom_range(0, 255);
         case ($urandom_range(0, 9))
            0:       w.mode = MODE_READ;
            1:       w = random_write();
            default: w.mode = MODE_TICK;
         endcase
         send_word(w);
      end
   endtask

   // Fully random words, undefined mode included
   task automatic run_noise();
      psg_word_type w;
      repeat ($urandom_range(2, 8)) begin
         w = '0;
         w.mode = $urandom_range(0, 3);
         w.addr = $urandom_range(0, NUM_REGS - 1);
         w.data = $urandom_range(0, 255);
         send_word(w);
      end
   endtask

   // Stimulus
   initial begin
      logic [STEP_INC_W-1:0] phase_steps [NUM_PHASES];
      int unsigned target;
      int p, c;

      reset          <= 1'b1;
      csr_write_en   <= 1'b0;
      csr_index      <= '0;
      csr_write_data <= '0;
      req.valid      <= 1'b0;
      req.mode       <= MODE_WRITE;
      req.reg_addr   <= '0;
      req.reg_data   <= '0;

      // Shadow state after reset
      cfg_chip_model = 1'b0;
      cfg_step = STEP_INC_W'(1) << FRAC;
      for (c = 0; c < NUM_REGS; c++) sh_regs[c] = '0;
      for (c = 0; c < NUM_CH; c++) begin
         sh_tone_period[c] = TONE_W'(1);
         sh_tone_cnt[c]    = '0;
         sh_tone_out[c]    = 1'b0;
         sh_tone_en[c]     = 1'b0;
         sh_noise_en[c]    = 1'b0;
         sh_use_env[c]     = 1'b0;
         sh_vol_idx[c]     = '0;
      end
      sh_lfsr           = NOISE_SEED;
      sh_noise_period   = '0;
      sh_noise_cnt      = '0;
      sh_env_period     = ENV_PER_W'(1);
      sh_env_cnt        = '0;
      sh_env_pos        = '0;
      sh_env_dir        = ENV_STOP;
      sh_env_hold       = 1'b0;
      sh_env_alt        = 1'b0;
      sh_env_final_high = 1'b0;
      sh_phase          = '0;

      phase_steps = '{STEP_INC_W'(1) << FRAC, STEP_INC_W'(1) << 28, STEP_INC_W'(1), '0,
                      '1, STEP_INC_W'(3) << (FRAC - 1),
                      STEP_INC_W'($urandom_range(1, 32'h1000_0000)), STEP_INC_W'(1) << FRAC};

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed words under reset configuration
      foreach (directed_rows[i]) send_word(directed_rows[i]);
      drain();

      // Random phases, each under its own table and step setting
      for (p = 0; p < NUM_PHASES; p++) begin
         set_config(CSR_CHIP_MODEL, STEP_INC_W'(p % 2));
         set_config(CSR_STEP_INCREMENT, phase_steps[p]);
         if (p == 1) hold_rsp_request = 1'b1;
         target = words_sent + PHASE_WORDS;
         while (words_sent < target) begin
            if ($urandom_range(0, 4) != 0) run_scene();
            else run_noise();
         end
         drain();
      end

      repeat (8) @(posedge clock);
      if (sent_words.size() != 0 || rsp_due.size() != 0) begin
         $error("%0d responses still due at end of run", rsp_due.size() + sent_words.size());
         errors++;
      end
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
